// ===== design/dedr_pkg.sv =====
package dedr_pkg;

    localparam int COORD_W   = 20;
    localparam int NORM_W    = 16;
    localparam int STEP_W    = 13;
    localparam int GEO_W     = 32;
    localparam int PERP_W    = 40;
    localparam int SKIP_W    = 5;
    localparam int PT_W      = 3 * COORD_W;

    // Coordinate differences, shared multiplier product, sum of squares, root.
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SQ_W      = 44;
    localparam int ROOT_W    = SQ_W / 2;

    // Iteration counts of the sequenced units.
    localparam int MOD_ITER  = STEP_W - 1;
    localparam int SQRT_ITER = SQ_W / 2;
    localparam int MAC_TERMS = 3;
    localparam int CNT_W     = 5;

    localparam logic [SKIP_W-1:0] SKIP_RESET = 5'd5;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PREP,
        CMD_MOD,
        CMD_SQ,
        CMD_SQRT,
        CMD_GEO,
        CMD_PERP,
        CMD_FIN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [CNT_W-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic edge_pix;
        logic no_edge;
        logic capped;
        logic mod_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/dedr_ram.sv =====
module dedr_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/dedr_ctrl.sv =====
module dedr_ctrl import dedr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_MOD  = 8'b0000_0100,
        S_SQ   = 8'b0000_1000,
        S_SQRT = 8'b0001_0000,
        S_GEO  = 8'b0010_0000,
        S_PERP = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = CMD_NONE;
        cmd.idx    = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op = CMD_PREP;
                if (status.edge_pix || status.no_edge)
                begin
                    state_next = S_FIN;
                end
                else if (status.capped)
                begin
                    state_next = S_PERP;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = S_MOD;
                    cnt_next   = CNT_W'(MOD_ITER - 1);
                end
            end
            S_MOD:
            begin
                cmd.op = CMD_MOD;
                if (cnt_reg == '0)
                begin
                    // A sample is due when the new count is a multiple of the skip.
                    state_next = status.mod_zero ? S_SQ : S_PERP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SQ:
            begin
                cmd.op = CMD_SQ;
                if (cnt_reg == CNT_W'(MAC_TERMS))
                begin
                    state_next = S_SQRT;
                    cnt_next   = CNT_W'(SQRT_ITER - 1);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                cmd.op = CMD_SQRT;
                if (cnt_reg == '0)
                begin
                    state_next = S_GEO;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_GEO:
            begin
                cmd.op     = CMD_GEO;
                state_next = S_PERP;
                cnt_next   = '0;
            end
            S_PERP:
            begin
                cmd.op = CMD_PERP;
                if (cnt_reg == CNT_W'(MAC_TERMS))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.op     = CMD_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/dedr_datapath.sv =====
module dedr_datapath import dedr_pkg::*; #(
    parameter int MAX_SKIP    = 16,
    parameter int MAX_RAY_LEN = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_we,
    input  logic [SKIP_W-1:0]        cfg_wdata,
    input  logic                     ray_start,
    input  logic                     edge_flag,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_depth,
    input  logic signed [NORM_W-1:0]  normal_x,
    input  logic signed [NORM_W-1:0]  normal_y,
    input  logic signed [NORM_W-1:0]  normal_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [STEP_W-1:0] steps_since_edge,
    output logic [GEO_W-1:0]         geodesic_dist,
    output logic signed [PERP_W-1:0] proj_dist
);

    localparam int HAW      = (MAX_SKIP > 1) ? $clog2(MAX_SKIP) : 1;
    localparam int SKW      = $clog2(MAX_SKIP + 1);
    localparam int IW       = SKW + 1;
    localparam int STEP_CAP = (MAX_RAY_LEN - 1 < 4095) ? MAX_RAY_LEN - 1 : 4095;

    // Configuration and ray state.
    logic [SKIP_W-1:0]        skip_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic [GEO_W-1:0]         geo_reg;
    logic [PT_W-1:0]          edge_pt_reg;
    logic [MAX_SKIP-1:0]      valid_reg;
    logic [HAW-1:0]           wp_reg;
    logic                     out_valid_reg;

    // Current item.
    logic                     edge_reg;
    logic [PT_W-1:0]          cur_pt_reg;
    logic [3*NORM_W-1:0]      norm_reg;

    // Sequenced arithmetic.
    logic                     old_valid_reg;
    logic [IW-1:0]            rem_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          res_reg;
    logic [PERP_W-1:0]        perp_reg;

    logic signed [STEP_W-1:0] steps_out_reg;
    logic [GEO_W-1:0]         geo_out_reg;
    logic [PERP_W-1:0]        perp_out_reg;

    logic [SKW-1:0]           skip_eff;
    logic [IW-1:0]            rd_sum;
    logic [HAW-1:0]           rd_addr;
    logic [HAW-1:0]           wp_inc;
    logic [PT_W-1:0]          rd_data;
    logic [IW-1:0]            rem_try;
    logic [IW-1:0]            rem_next;
    logic signed [COORD_W-1:0] c_cur, c_old, c_edge;
    logic signed [NORM_W-1:0]  c_norm;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SQ_W-1:0]          bit_val;
    logic [SQ_W-1:0]          trial;
    logic [GEO_W:0]           geo_sum;
    logic                     out_free;
    logic                     hist_we;

    always_comb
    begin
        if ({{(32-SKIP_W){1'b0}}, skip_reg} > 32'(MAX_SKIP))
        begin
            skip_eff = SKW'(MAX_SKIP);
        end
        else if (skip_reg == '0)
        begin
            skip_eff = SKW'(1);
        end
        else
        begin
            skip_eff = SKW'(skip_reg);
        end
    end

    // History slot written skip steps back, wrapping around the line.
    assign rd_sum  = (IW'(wp_reg) >= IW'(skip_eff)) ? IW'(wp_reg) - IW'(skip_eff)
                   : IW'(wp_reg) + IW'(MAX_SKIP) - IW'(skip_eff);
    assign rd_addr = rd_sum[HAW-1:0];
    assign wp_inc  = (wp_reg == HAW'(MAX_SKIP - 1)) ? '0 : wp_reg + 1'b1;

    // One bit of the restoring remainder of the step count by the skip.
    assign rem_try  = {rem_reg[IW-2:0], step_reg[cmd.idx[3:0]]};
    assign rem_next = (rem_try >= IW'(skip_eff)) ? rem_try - IW'(skip_eff) : rem_try;

    always_comb
    begin
        case (cmd.idx[1:0])
            2'd1:
            begin
                c_cur  = cur_pt_reg[2*COORD_W-1:COORD_W];
                c_old  = rd_data[2*COORD_W-1:COORD_W];
                c_edge = edge_pt_reg[2*COORD_W-1:COORD_W];
                c_norm = norm_reg[2*NORM_W-1:NORM_W];
            end
            2'd2:
            begin
                c_cur  = cur_pt_reg[COORD_W-1:0];
                c_old  = rd_data[COORD_W-1:0];
                c_edge = edge_pt_reg[COORD_W-1:0];
                c_norm = norm_reg[NORM_W-1:0];
            end
            default:
            begin
                c_cur  = cur_pt_reg[3*COORD_W-1:2*COORD_W];
                c_old  = rd_data[3*COORD_W-1:2*COORD_W];
                c_edge = edge_pt_reg[3*COORD_W-1:2*COORD_W];
                c_norm = norm_reg[3*NORM_W-1:2*NORM_W];
            end
        endcase
        // A history slot not written since the ray began reads as the origin.
        if (!old_valid_reg)
        begin
            c_old = '0;
        end
        if (cmd.op == CMD_SQ)
        begin
            mul_a = DIFF_W'(c_cur) - DIFF_W'(c_old);
            mul_b = mul_a;
        end
        else
        begin
            mul_a = DIFF_W'(c_norm);
            mul_b = DIFF_W'(c_edge) - DIFF_W'(c_cur);
        end
    end

    assign mul_p = mul_a * mul_b;

    assign bit_val = SQ_W'(1) << {cmd.idx, 1'b0};
    assign trial   = res_reg + bit_val;
    assign geo_sum = {1'b0, geo_reg} + (GEO_W + 1)'(res_reg[ROOT_W-1:0]);

    assign out_free = !out_valid_reg || out_ready;
    assign hist_we  = (cmd.op == CMD_FIN);

    assign status.edge_pix = edge_reg;
    assign status.no_edge  = step_reg[STEP_W-1];
    assign status.capped   = step_reg >= STEP_W'(STEP_CAP);
    assign status.mod_zero = (rem_next == '0);
    assign status.out_free = out_free;

    dedr_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_SKIP)
    ) u_hist (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (wp_reg),
        .wr_data (cur_pt_reg),
        .rd_en   (cmd.op == CMD_PREP),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= SKIP_RESET;
            step_reg      <= '1;
            geo_reg       <= '0;
            edge_pt_reg   <= '0;
            valid_reg     <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                skip_reg <= cfg_wdata;
            end
            if (cmd.op == CMD_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                CMD_LOAD:
                begin
                    if (ray_start)
                    begin
                        step_reg    <= '1;
                        geo_reg     <= '0;
                        edge_pt_reg <= '0;
                        valid_reg   <= '0;
                        wp_reg      <= '0;
                    end
                end
                CMD_PREP:
                begin
                    if (edge_reg)
                    begin
                        step_reg    <= '0;
                        geo_reg     <= '0;
                        edge_pt_reg <= cur_pt_reg;
                    end
                    else if (!status.no_edge && !status.capped)
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                CMD_GEO:
                begin
                    geo_reg <= geo_sum[GEO_W] ? '1 : geo_sum[GEO_W-1:0];
                end
                CMD_FIN:
                begin
                    valid_reg[wp_reg] <= 1'b1;
                    wp_reg            <= wp_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                edge_reg   <= edge_flag;
                cur_pt_reg <= {point_x, point_y, point_depth};
                norm_reg   <= {normal_x, normal_y, normal_z};
            end
            CMD_PREP:
            begin
                old_valid_reg <= valid_reg[rd_addr];
                rem_reg       <= '0;
                perp_reg      <= '0;
            end
            CMD_MOD:
            begin
                rem_reg <= rem_next;
            end
            CMD_SQ:
            begin
                prod_reg <= mul_p;
                if (cmd.idx == '0)
                begin
                    sq_reg  <= '0;
                    res_reg <= '0;
                end
                else
                begin
                    sq_reg <= sq_reg + SQ_W'($unsigned(prod_reg));
                end
            end
            CMD_SQRT:
            begin
                if (sq_reg >= trial)
                begin
                    sq_reg  <= sq_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_val;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            CMD_PERP:
            begin
                prod_reg <= mul_p;
                if (cmd.idx == '0)
                begin
                    perp_reg <= '0;
                end
                else
                begin
                    perp_reg <= perp_reg + prod_reg[PERP_W-1:0];
                end
            end
            CMD_FIN:
            begin
                steps_out_reg <= step_reg;
                geo_out_reg   <= geo_reg;
                perp_out_reg  <= perp_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign steps_since_edge = steps_out_reg;
    assign geodesic_dist    = geo_out_reg;
    assign proj_dist        = $signed(perp_out_reg);

endmodule

// ===== design/diagonal_edge_distance_ray.sv =====
// Edge distance features along one diagonal ray of pixels.
// Pixels arrive in ray order on the input channel (in_valid / in_ready); a
// pixel with ray_start set clears the ray state before it is processed. Each
// request yields exactly one result on the output channel (out_valid /
// out_ready): steps since the last edge, the sampled geodesic path length and
// the projected distance of the pixel to the edge point along its normal.
// sample_skip is written through cfg_we / cfg_wdata; the user must write it
// only while no pixel is in flight; the block itself has no guard for this. It
// takes effect on the next pixel. Pixels are handled one at a time: an edge
// pixel or a pixel before any edge goes from preparation to the result, a
// pixel past a saturated count takes only the projection, a pixel without a
// sample also the remainder and one with a sample also the squared distance,
// root and geodesic update; the result enters the output register in the
// cycle before the next pixel can be accepted. The long cases are set by the
// bit-serial remainder of the count by the skip, the shared 21x21 multiplier
// and the bit-pair square root.
// The result sits in an output register; while the receiver stalls, the next
// pixel is still accepted and worked on, and holds only at its final step.
// Reset clears the ray state, the history valid bits and sample_skip to 5.
module diagonal_edge_distance_ray import dedr_pkg::*; #(
    parameter int MAX_SKIP    = 16,
    parameter int MAX_RAY_LEN = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [SKIP_W-1:0]         cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      ray_start,
    input  logic                      edge_flag,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_depth,
    input  logic signed [NORM_W-1:0]  normal_x,
    input  logic signed [NORM_W-1:0]  normal_y,
    input  logic signed [NORM_W-1:0]  normal_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [STEP_W-1:0]  steps_since_edge,
    output logic [GEO_W-1:0]          geodesic_dist,
    output logic signed [PERP_W-1:0]  proj_dist
);

    dp_cmd_t    cmd;
    dp_status_t status;

    dedr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dedr_datapath #(
        .MAX_SKIP    (MAX_SKIP),
        .MAX_RAY_LEN (MAX_RAY_LEN)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .ray_start        (ray_start),
        .edge_flag        (edge_flag),
        .point_x          (point_x),
        .point_y          (point_y),
        .point_depth      (point_depth),
        .normal_x         (normal_x),
        .normal_y         (normal_y),
        .normal_z         (normal_z),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .steps_since_edge (steps_since_edge),
        .geodesic_dist    (geodesic_dist),
        .proj_dist        (proj_dist)
    );

endmodule
